/* rtl/hrlps_pkg.sv */
// Shared types and constants for the HTTP request line path sanitizer.
`timescale 1ns / 1ps

package hrlps_pkg;

  // Most results one request byte can cause: '/', two held dots, the byte itself.
  localparam int GROUP_MAX   = 4;
  // Entries in the result queue ahead of the output register.
  localparam int QUEUE_DEPTH = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  localparam logic KIND_PATH   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  path_byte;
    logic        status;
    logic [55:0] method_text;
    logic [2:0]  method_length;
    logic [55:0] version_text;
    logic [2:0]  version_length;
    logic [9:0]  path_length;
    logic        last_of_run;
  } result_t;

  // Results of one request byte, slot 0 first.
  typedef struct packed {
    logic [2:0]                  count;
    result_t [GROUP_MAX-1:0]     slot;
  } group_t;

endpackage

/* rtl/hrlps_parser.sv */
// Request line tokenizer and path sanitizer: one request byte per step.
`timescale 1ns / 1ps

module hrlps_parser import hrlps_pkg::*; #(
  parameter int PATH_CAP        = 1024,
  parameter int PATH_TOKEN_MAX  = 2047,
  parameter int SHORT_TOKEN_MAX = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_value,
  input  logic       end_req,
  output group_t     grp
);

  localparam int TCW = $clog2(PATH_TOKEN_MAX + 1);
  localparam int SCW = $clog2(SHORT_TOKEN_MAX + 1);
  localparam int ECW = $clog2(PATH_CAP);

  typedef enum logic [2:0] {
    PH_METHOD_SKIP,
    PH_METHOD_IN,
    PH_PATH_SKIP,
    PH_PATH_IN,
    PH_VERSION_SKIP,
    PH_VERSION_IN,
    PH_DONE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [TCW-1:0]   tok_r, tok_nxt;
  logic [55:0]      mstore_r, mstore_nxt;
  logic [SCW-1:0]   mcnt_r, mcnt_nxt;
  logic [55:0]      vstore_r, vstore_nxt;
  logic [SCW-1:0]   vcnt_r, vcnt_nxt;
  logic [1:0]       held_r, held_nxt;
  logic             seg_open_r, seg_open_nxt;
  logic             query_r, query_nxt;
  logic [ECW-1:0]   ecnt_r, ecnt_nxt;
  logic             failed_r, failed_nxt;

  logic [7:0]       cand [GROUP_MAX];
  logic [2:0]       ncand;
  logic [2:0]       n_w;
  logic             do_end;
  logic             sp;
  logic [TCW-1:0]   tok_base;
  logic [SCW+2:0]   mlen_ext;
  logic [SCW+2:0]   vlen_ext;
  logic [ECW+9:0]   plen_ext;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  always_comb begin
    phase_nxt    = phase_r;
    tok_nxt      = tok_r;
    mstore_nxt   = mstore_r;
    mcnt_nxt     = mcnt_r;
    vstore_nxt   = vstore_r;
    vcnt_nxt     = vcnt_r;
    held_nxt     = held_r;
    seg_open_nxt = seg_open_r;
    query_nxt    = query_r;
    ecnt_nxt     = ecnt_r;
    failed_nxt   = failed_r;
    ncand        = 3'd0;
    do_end       = 1'b0;
    tok_base     = tok_r;
    sp           = is_space(byte_value);
    for (int k = 0; k < GROUP_MAX; k++) begin
      cand[k] = CH_NUL;
    end

    if (phase_r != PH_DONE && byte_value == CH_NUL) begin
      phase_nxt = PH_DONE;
    end else begin
      case (phase_r)
        PH_METHOD_SKIP, PH_METHOD_IN: begin
          if (!sp) begin
            for (int i = 0; i < 7; i++) begin
              if (32'(mcnt_r) == i) mstore_nxt[8*i +: 8] = byte_value;
            end
            mcnt_nxt  = mcnt_r + 1'b1;
            phase_nxt = (mcnt_nxt >= SCW'(SHORT_TOKEN_MAX)) ? PH_PATH_SKIP : PH_METHOD_IN;
          end else if (phase_r == PH_METHOD_IN) begin
            phase_nxt = PH_PATH_SKIP;
          end
        end
        PH_PATH_SKIP, PH_PATH_IN: begin
          if (sp) begin
            do_end = (phase_r == PH_PATH_IN);
          end else begin
            tok_base  = (phase_r == PH_PATH_SKIP) ? '0 : tok_r;
            phase_nxt = PH_PATH_IN;
            if (!query_r) begin
              if (byte_value == CH_SLASH) begin
                seg_open_nxt = 1'b0;
                held_nxt     = 2'd0;
              end else if (byte_value == CH_QMARK) begin
                seg_open_nxt = 1'b0;
                held_nxt     = 2'd0;
                query_nxt    = 1'b1;
              end else if (!seg_open_r) begin
                seg_open_nxt = 1'b1;
                if (byte_value == CH_DOT) begin
                  held_nxt = 2'd1;
                end else begin
                  cand[0] = CH_SLASH;
                  cand[1] = byte_value;
                  ncand   = 3'd2;
                end
              end else if (held_r != 2'd0) begin
                if (byte_value == CH_DOT && held_r == 2'd1) begin
                  held_nxt = 2'd2;
                end else begin
                  // release the held dots in front of this byte
                  cand[0]  = CH_SLASH;
                  cand[1]  = CH_DOT;
                  cand[2]  = (held_r == 2'd2) ? CH_DOT : byte_value;
                  cand[3]  = byte_value;
                  ncand    = (held_r == 2'd2) ? 3'd4 : 3'd3;
                  held_nxt = 2'd0;
                end
              end else begin
                cand[0] = byte_value;
                ncand   = 3'd1;
              end
            end
            tok_nxt = tok_base + 1'b1;
            if (tok_nxt >= TCW'(PATH_TOKEN_MAX)) do_end = 1'b1;
          end
        end
        PH_VERSION_SKIP, PH_VERSION_IN: begin
          if (!sp) begin
            for (int i = 0; i < 7; i++) begin
              if (32'(vcnt_r) == i) vstore_nxt[8*i +: 8] = byte_value;
            end
            vcnt_nxt  = vcnt_r + 1'b1;
            phase_nxt = (vcnt_nxt >= SCW'(SHORT_TOKEN_MAX)) ? PH_DONE : PH_VERSION_IN;
          end else if (phase_r == PH_VERSION_IN) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_end) begin
      seg_open_nxt = 1'b0;
      held_nxt     = 2'd0;
      phase_nxt    = PH_VERSION_SKIP;
    end

    // Capacity check per byte; once failed nothing further goes out, so the
    // emitted bytes are always a prefix of the candidates.
    n_w = 3'd0;
    for (int k = 0; k < GROUP_MAX; k++) begin
      if (k < int'(ncand) && !end_req && !failed_nxt) begin
        if (ecnt_nxt >= ECW'(PATH_CAP - 1)) begin
          failed_nxt = 1'b1;
        end else begin
          n_w      = 3'(k + 1);
          ecnt_nxt = ecnt_nxt + 1'b1;
        end
      end
    end
    // empty path turns into a single slash
    if (do_end && ecnt_nxt == '0 && !end_req && !failed_nxt) begin
      cand[0]  = CH_SLASH;
      n_w      = 3'd1;
      ecnt_nxt = ecnt_nxt + 1'b1;
    end

    mlen_ext = {3'b000, mcnt_nxt};
    vlen_ext = {3'b000, vcnt_nxt};
    plen_ext = {10'd0, ecnt_r};

    grp.count = n_w;
    for (int k = 0; k < GROUP_MAX; k++) begin
      grp.slot[k]             = '0;
      grp.slot[k].kind        = KIND_PATH;
      grp.slot[k].path_byte   = cand[k];
      grp.slot[k].last_of_run = (3'(k + 1) == n_w);
    end
    if (end_req) begin
      grp.count                   = 3'd1;
      grp.slot[0]                 = '0;
      grp.slot[0].kind            = KIND_STATUS;
      grp.slot[0].status          = (vcnt_nxt != '0 && !failed_r) ? ST_OK : ST_BAD;
      grp.slot[0].method_text     = mstore_nxt;
      grp.slot[0].method_length   = mlen_ext[2:0];
      grp.slot[0].version_text    = vstore_nxt;
      grp.slot[0].version_length  = vlen_ext[2:0];
      grp.slot[0].path_length     = plen_ext[9:0];
      grp.slot[0].last_of_run     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_req)) begin
      phase_r    <= PH_METHOD_SKIP;
      tok_r      <= '0;
      mstore_r   <= '0;
      mcnt_r     <= '0;
      vstore_r   <= '0;
      vcnt_r     <= '0;
      held_r     <= 2'd0;
      seg_open_r <= 1'b0;
      query_r    <= 1'b0;
      ecnt_r     <= '0;
      failed_r   <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tok_r      <= tok_nxt;
      mstore_r   <= mstore_nxt;
      mcnt_r     <= mcnt_nxt;
      vstore_r   <= vstore_nxt;
      vcnt_r     <= vcnt_nxt;
      held_r     <= held_nxt;
      seg_open_r <= seg_open_nxt;
      query_r    <= query_nxt;
      ecnt_r     <= ecnt_nxt;
      failed_r   <= failed_nxt;
    end
  end

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_req |-> grp.count == 3'd1 && grp.slot[0].kind == KIND_STATUS)
    else $error("status result not alone in its group");

  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= ECW'(PATH_CAP - 1))
    else $error("emitted path count reached capacity");

  a_request_reset: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_req |=> phase_r == PH_METHOD_SKIP && ecnt_r == '0 && !failed_r)
    else $error("state not cleared after status");

endmodule

/* rtl/hrlps_outq.sv */
// Result queue with group writes and a registered output stage.
`timescale 1ns / 1ps

module hrlps_outq import hrlps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  group_t  wr_grp,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = PW + 1;

  result_t        mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           out_vld_r, out_vld_nxt;
  result_t        out_item_r;
  logic [2:0]     wr_n;
  logic           pop;

  assign wr_n = wr_en ? wr_grp.count : 3'd0;
  assign pop  = (cnt_r != '0) && (!out_vld_r || !out_stall);
  assign room = (cnt_r <= CW'(QUEUE_DEPTH - GROUP_MAX));

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r + PW'(wr_n);
    rd_ptr_nxt  = rd_ptr_r + PW'(pop);
    cnt_nxt     = cnt_r + CW'(wr_n) - CW'(pop);
    out_vld_nxt = pop ? 1'b1 : (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < GROUP_MAX; k++) begin
      if (k < int'(wr_n)) mem[wr_ptr_r + PW'(k)] <= wr_grp.slot[k];
    end
    if (pop) out_item_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> room)
    else $error("group written without room");

  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_vld_r)
    else $error("popped entry not presented");

endmodule

/* rtl/http_request_line_path_sanitizer.sv */
// Top level of the HTTP request line path sanitizer.
`timescale 1ns / 1ps

// Channel  Ports                                         Direction  Moves per transfer
// in_      in_valid in_stall in_byte_value                in         one request byte
//          in_end_of_request
// out_     out_valid out_stall out_kind out_path_byte ...  out        one path byte or status
//
// Cycles: a request byte is taken every cycle while in_stall is low; it is
// held in the input register, where the parser turns it into up to four
// results. Results pass through an eight-entry queue and the output
// register, one per cycle while out_stall is low; the first result of a
// byte passes the input register, the queue and the output register in turn.
// Stalls: input stalls only while the queue holds more than four results,
// which happens when output is stalled or when held dots drain in a burst.
// Reset: synchronous, active low; clears parser state and the queue.
module http_request_line_path_sanitizer import hrlps_pkg::*; #(
  parameter int PATH_CAP        = 1024,
  parameter int PATH_TOKEN_MAX  = 2047,
  parameter int SHORT_TOKEN_MAX = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_path_byte,
  output logic        out_status,
  output logic [55:0] out_method_text,
  output logic [2:0]  out_method_length,
  output logic [55:0] out_version_text,
  output logic [2:0]  out_version_length,
  output logic [9:0]  out_path_length,
  output logic        out_last_of_run
);

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       in_take;
  logic       step;
  logic       room;
  group_t     grp;
  result_t    out_item;

  // Hold the byte in the input register until the queue can take all of its
  // results; accept a new transfer whenever that register empties.
  assign step       = in_vld_r && room;
  assign in_stall   = in_vld_r && !room;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte_value;
      in_end_r  <= in_end_of_request;
    end
  end

  hrlps_parser #(
    .PATH_CAP        (PATH_CAP),
    .PATH_TOKEN_MAX  (PATH_TOKEN_MAX),
    .SHORT_TOKEN_MAX (SHORT_TOKEN_MAX)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .byte_value (in_byte_r),
    .end_req    (in_end_r),
    .grp        (grp)
  );

  hrlps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (step),
    .wr_grp    (grp),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // drive result ports from the output register
  assign out_kind           = out_item.kind;
  assign out_path_byte      = out_item.path_byte;
  assign out_status         = out_item.status;
  assign out_method_text    = out_item.method_text;
  assign out_method_length  = out_item.method_length;
  assign out_version_text   = out_item.version_text;
  assign out_version_length = out_item.version_length;
  assign out_path_length    = out_item.path_length;
  assign out_last_of_run    = out_item.last_of_run;

endmodule
